>>> hw/rtl/light_meter_exposure_advisor_defines.svh
// Assertion macros shared by the light meter exposure advisor RTL.
`ifndef LIGHT_METER_EXPOSURE_ADVISOR_DEFINES_SVH
`define LIGHT_METER_EXPOSURE_ADVISOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LMEA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LMEA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/lmea_pkg.sv
// Types, codes and constants of the light meter exposure advisor.
package lmea_pkg;

    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int DIVIDEND_W  = 34;
    localparam int DIVISOR_W   = 17;
    localparam int DIV_CNT_W   = 6;

    localparam logic [15:0] OVER_LIMIT  = 16'd44250;
    localparam logic [17:0] FAST_MARGIN = 18'd6;
    localparam logic [17:0] SLOW_MARGIN = 18'd128;

    typedef enum logic [1:0] {
        CMD_PULSE  = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_EVAL   = 2'd2,
        CMD_TWRITE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_AUTO   = 2'd1,
        MODE_MANUAL = 2'd2,
        MODE_QUIET  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        FILM_A   = 2'd0,
        FILM_B   = 2'd1,
        FILM_ISO = 2'd2,
        FILM_RAW = 2'd3
    } film_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_WAIT = 2'd1,
        STAT_OVER = 2'd2,
        STAT_OFF  = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTERVAL  = 3'd0,
        CFG_CMP_A     = 3'd1,
        CFG_CMP_B     = 3'd2,
        CFG_OFFSET    = 3'd3,
        CFG_LOW_LIGHT = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_ADD,
        ST_SCAN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    localparam logic [15:0] SPEED_RESET [12] = '{
        16'd17, 16'd20, 16'd23, 16'd25, 16'd30, 16'd35,
        16'd45, 16'd55, 16'd68, 16'd102, 16'd166, 16'd302
    };

    // Power-up speed of a slot; slots past the list repeat the slowest entry.
    function automatic logic [15:0] speed_reset(input logic [7:0] idx);
        logic [15:0] val;
        if (idx < 8'd12) begin
            val = SPEED_RESET[idx[3:0]];
        end else begin
            val = SPEED_RESET[11];
        end
        return val;
    endfunction

endpackage

>>> hw/rtl/lmea_div.sv
// Restoring divider, one quotient bit per cycle.
module lmea_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [lmea_pkg::DIVIDEND_W-1:0]    dividend,
    input  logic [lmea_pkg::DIVISOR_W-1:0]     divisor,
    output logic [lmea_pkg::DIVIDEND_W-1:0]    quotient,
    output lmea_pkg::div_stat_t                stat
);
    import lmea_pkg::*;

    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  den_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIVIDEND_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            den_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> hw/rtl/light_meter_exposure_advisor.sv
// Top level of the light meter exposure advisor.
// Input beats on s_*: cmd in s_tuser; pulse, tick and table-write beats produce
// no result. An evaluate beat produces exactly one result beat on m_*.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata; the
// user must write them only while the block is idle, which the block itself
// does not enforce; indexes beyond the register list are dropped.
// Off or still-measuring evaluates go from idle straight to the output step. A
// full prediction runs a multiply step, a 34-step restoring divider, the offset
// add, and in manual mode a scan of the speed table through the single read port
// of the table memory, one entry per cycle, with its read data registered.
// s_tready is high only while no evaluate is in progress, so evaluates run one
// at a time; one result is buffered in the output register.
// Reset: counters, lamps and output valid clear; the speed table reads its
// power-up values through per-slot valid bits, so no clearing pass is needed.
// A stalled receiver holds the result in the output register; pulses, ticks and
// table writes are still taken meanwhile, and a further evaluate waits with its
// finished result until the register frees.
`include "light_meter_exposure_advisor_defines.svh"

module light_meter_exposure_advisor #(
    parameter int TABLE_SLOTS = 12
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [lmea_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lmea_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // from bit 0: selector[3:0] mode[5:4] film_kind[7:6] iso_value[23:8]
    // table_index[27:24] table_value[43:28], zero pad [47:44]
    input  logic [lmea_pkg::S_TDATA_W-1:0]     s_tdata,
    // from bit 0: cmd[1:0]
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // from bit 0: lamp_blue[0] lamp_red[1] exposure[17:2] slot_code[21:18]
    // status[23:22]
    output logic [lmea_pkg::M_TDATA_W-1:0]     m_tdata
);
    import lmea_pkg::*;

    localparam int IDX_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
    localparam int SLOT_W = $clog2(TABLE_SLOTS + 2);
    localparam int SEL_W  = (SLOT_W > 4) ? SLOT_W : 4;

    // ---------------- input field split ----------------
    cmd_t        in_cmd;
    logic [3:0]  in_sel;
    mode_t       in_mode;
    film_t       in_film;
    logic [15:0] in_iso;
    logic [3:0]  in_tidx;
    logic [15:0] in_tval;

    assign in_cmd  = cmd_t'(s_tuser);
    assign in_sel  = s_tdata[3:0];
    assign in_mode = mode_t'(s_tdata[5:4]);
    assign in_film = film_t'(s_tdata[7:6]);
    assign in_iso  = s_tdata[23:8];
    assign in_tidx = s_tdata[27:24];
    assign in_tval = s_tdata[43:28];

    logic s_acc;
    logic eval_acc;
    assign s_acc    = s_tvalid && s_tready;
    assign eval_acc = s_acc && (in_cmd == CMD_EVAL);

    // ---------------- configuration registers ----------------
    logic [15:0] interval_reg;
    logic [15:0] cmp_a_reg;
    logic [15:0] cmp_b_reg;
    logic [11:0] offset_reg;
    logic [15:0] low_light_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg  <= 16'd200;
            cmp_a_reg     <= 16'd256;
            cmp_b_reg     <= 16'd256;
            offset_reg    <= 12'd0;
            low_light_reg <= 16'd100;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_INTERVAL:  interval_reg  <= cfg_wdata;
                CFG_CMP_A:     cmp_a_reg     <= cfg_wdata;
                CFG_CMP_B:     cmp_b_reg     <= cfg_wdata;
                CFG_OFFSET:    offset_reg    <= cfg_wdata[11:0];
                CFG_LOW_LIGHT: low_light_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- state machine ----------------
    state_t state_reg;
    state_t state_next;

    logic   meas_reg;
    logic [15:0] elapsed_reg;
    logic [15:0] pulse_reg;

    logic   early_done;     // evaluate answered without a prediction
    logic   out_load;
    logic   m_tvalid_reg;
    div_stat_t div_stat;

    logic              rd_pend_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    mode_t             mode_lat_reg;

    assign early_done = (in_mode == MODE_OFF) || !meas_reg || (elapsed_reg < interval_reg);
    assign out_load   = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (eval_acc) begin
                    if (early_done) begin
                        state_next = ST_OUT;
                    end else if (pulse_reg == 16'd0) begin
                        state_next = (in_mode == MODE_MANUAL) ? ST_SCAN : ST_OUT;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:  state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: state_next = (mode_lat_reg == MODE_MANUAL) ? ST_SCAN : ST_OUT;
            ST_SCAN: begin
                if (rd_pend_reg && (rd_idx_reg == IDX_W'(TABLE_SLOTS - 1))) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- measurement counters ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meas_reg    <= 1'b0;
            elapsed_reg <= '0;
            pulse_reg   <= '0;
        end else if (s_acc) begin
            case (in_cmd)
                CMD_PULSE: pulse_reg <= pulse_reg + 1'b1;
                CMD_TICK: begin
                    if (elapsed_reg != 16'hFFFF) begin
                        elapsed_reg <= elapsed_reg + 1'b1;
                    end
                end
                CMD_EVAL: begin
                    if (in_mode != MODE_OFF) begin
                        if (!meas_reg) begin
                            // open a new window
                            meas_reg    <= 1'b1;
                            elapsed_reg <= '0;
                            pulse_reg   <= '0;
                        end else if (elapsed_reg >= interval_reg) begin
                            meas_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- evaluate datapath ----------------
    logic [3:0]          sel_lat_reg;
    logic [15:0]         cmp_lat_reg;
    status_t             status_reg;
    logic signed [17:0]  pred_reg;
    logic [15:0]         expo_reg;
    logic [31:0]         prod_reg;

    logic [DIVIDEND_W-1:0] div_quo;
    logic [DIVIDEND_W:0]   sum;
    logic                  over;

    assign sum  = {1'b0, div_quo} + (DIVIDEND_W + 1)'(offset_reg);
    assign over = sum > (DIVIDEND_W + 1)'(OVER_LIMIT);

    always_ff @(posedge aclk) begin
        if (eval_acc) begin
            sel_lat_reg  <= in_sel;
            mode_lat_reg <= in_mode;
            case (in_film)
                FILM_A:  cmp_lat_reg <= cmp_a_reg;
                FILM_B:  cmp_lat_reg <= cmp_b_reg;
                default: cmp_lat_reg <= in_iso;
            endcase
            expo_reg <= '0;
            pred_reg <= -18'sd2;
            if (in_mode == MODE_OFF) begin
                status_reg <= STAT_OFF;
            end else if (early_done) begin
                status_reg <= STAT_WAIT;
            end else begin
                // zero pulses: overrange; otherwise overwritten after the divide
                status_reg <= STAT_OVER;
            end
        end else if (state_reg == ST_MUL) begin
            prod_reg <= elapsed_reg * cmp_lat_reg;
        end else if (state_reg == ST_ADD) begin
            if (over) begin
                status_reg <= STAT_OVER;
                pred_reg   <= -18'sd2;
            end else begin
                status_reg <= STAT_OK;
                expo_reg   <= sum[15:0];
                pred_reg   <= $signed({2'b00, sum[15:0]});
            end
        end
    end

    // half-up rounding: (2*ms*cmp + pulses) / (2*pulses)
    lmea_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_LOAD),
        .dividend ({1'b0, prod_reg, 1'b0} + DIVIDEND_W'(pulse_reg)),
        .divisor  ({pulse_reg, 1'b0}),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // ---------------- speed table memory ----------------
    logic [15:0]       tbl_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] tbl_vld_reg;
    logic [SEL_W-1:0]  tidx_ext;
    logic              tbl_we;
    logic [IDX_W-1:0]  tbl_waddr;

    logic [CNT_W-1:0]  scan_addr_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic [15:0]       rd_mem_reg;
    logic              rd_vld_reg;
    logic [15:0]       rd_val;

    assign tidx_ext  = SEL_W'(in_tidx);
    assign tbl_we    = s_acc && (in_cmd == CMD_TWRITE) && (tidx_ext < SEL_W'(TABLE_SLOTS));
    assign tbl_waddr = tidx_ext[IDX_W-1:0];
    assign rd_addr   = scan_addr_reg[IDX_W-1:0];

    // Writes happen only in idle; the read port reads unconditionally, but its
    // result is used only while scanning, when no write can be taken.
    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[tbl_waddr] <= in_tval;
        end
        rd_mem_reg <= tbl_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tbl_vld_reg <= '0;
        end else if (tbl_we) begin
            tbl_vld_reg[tbl_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_addr_reg <= '0;
            rd_pend_reg   <= 1'b0;
        end else begin
            rd_pend_reg <= (state_reg == ST_SCAN) && (scan_addr_reg < CNT_W'(TABLE_SLOTS));
            if (state_reg != ST_SCAN) begin
                scan_addr_reg <= '0;
            end else if (scan_addr_reg < CNT_W'(TABLE_SLOTS)) begin
                scan_addr_reg <= scan_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_vld_reg <= tbl_vld_reg[rd_addr];
        rd_idx_reg <= rd_addr;
    end

    // unwritten slots read their power-up speed
    assign rd_val = rd_vld_reg ? rd_mem_reg : speed_reset(8'(rd_idx_reg));

    // ---------------- nearest-slot search ----------------
    logic signed [17:0] dist_s;
    logic [16:0]        dist_abs;
    logic [16:0]        best_dist_reg;
    logic [IDX_W-1:0]   best_reg;
    logic [15:0]        tab_first_reg;
    logic [15:0]        tab_last_reg;

    assign dist_s   = $signed({2'b00, rd_val}) - pred_reg;
    assign dist_abs = dist_s[17] ? 17'(-dist_s) : dist_s[16:0];

    always_ff @(posedge aclk) begin
        if (rd_pend_reg) begin
            if (rd_idx_reg == '0) begin
                best_reg      <= '0;
                best_dist_reg <= dist_abs;
                tab_first_reg <= rd_val;
            end else if (dist_abs < best_dist_reg) begin
                // strict compare: ties keep the lower slot
                best_reg      <= rd_idx_reg;
                best_dist_reg <= dist_abs;
            end
            if (rd_idx_reg == IDX_W'(TABLE_SLOTS - 1)) begin
                tab_last_reg <= rd_val;
            end
        end
    end

    // ---------------- result and lamps ----------------
    logic              too_fast;
    logic              too_slow;
    logic [SEL_W-1:0]  slot_full;
    logic [SEL_W-1:0]  sel_ext;
    logic              computed;
    logic              lamp_blue_reg, lamp_red_reg;
    logic              lamp_blue_next, lamp_red_next;
    logic              auto_on;
    logic [3:0]        slot_out;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    assign too_fast = pred_reg < ($signed({2'b00, tab_first_reg}) - $signed(FAST_MARGIN));
    assign too_slow = pred_reg > ($signed({2'b00, tab_last_reg}) + $signed(SLOW_MARGIN));
    assign slot_full = too_fast ? SEL_W'(TABLE_SLOTS + 1) :
                       too_slow ? SEL_W'(TABLE_SLOTS) : SEL_W'(best_reg);
    assign sel_ext  = SEL_W'(sel_lat_reg);
    assign computed = (status_reg == STAT_OK) || (status_reg == STAT_OVER);
    assign auto_on  = (status_reg == STAT_OK) && (expo_reg > low_light_reg);
    assign slot_out = (computed && (mode_lat_reg == MODE_MANUAL)) ? slot_full[3:0] : 4'd0;

    always_comb begin
        lamp_blue_next = lamp_blue_reg;
        lamp_red_next  = lamp_red_reg;
        case (status_reg)
            STAT_OFF: begin
                lamp_blue_next = 1'b0;
                lamp_red_next  = 1'b0;
            end
            STAT_OK, STAT_OVER: begin
                if (mode_lat_reg == MODE_MANUAL) begin
                    if (too_fast) begin
                        lamp_red_next  = !lamp_red_reg;
                        lamp_blue_next = 1'b0;
                    end else if (too_slow) begin
                        lamp_red_next  = 1'b0;
                        lamp_blue_next = !lamp_blue_reg;
                    end else begin
                        lamp_blue_next = sel_ext < slot_full;
                        lamp_red_next  = sel_ext > slot_full;
                    end
                end else if (mode_lat_reg == MODE_AUTO) begin
                    lamp_blue_next = auto_on;
                    lamp_red_next  = auto_on;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lamp_blue_reg <= 1'b0;
            lamp_red_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (out_load) begin
                lamp_blue_reg <= lamp_blue_next;
                lamp_red_reg  <= lamp_red_next;
                m_tvalid_reg  <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {status_reg, slot_out, expo_reg, lamp_red_next, lamp_blue_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- checks ----------------
    `LMEA_ASSERT_NOW(a_div_only_in_div, aclk, aresetn,
        div_stat.done, state_reg == ST_DIV, "divider finished outside the divide step")
    `LMEA_ASSERT_NEXT(a_eval_blocks_input, aclk, aresetn,
        eval_acc, !s_tready, "input taken while an evaluate is in progress")
    `LMEA_ASSERT_NOW(a_expo_only_ok, aclk, aresetn,
        m_tvalid && (m_tdata[23:22] != STAT_OK), m_tdata[17:2] == 16'd0,
        "exposure reported without a computed prediction")

endmodule
